// ===== hw/rtl/wfa_pkg.sv =====
// Package: table sizes, widths, status codes and sequencer states of the worst-fit allocator.
`timescale 1ns / 1ps

package wfa_pkg;

    localparam int FREE_SLOTS = 16;
    localparam int USED_SLOTS = 16;
    localparam int ADDR_WIDTH = 32;

    localparam int FREE_IDX_W = $clog2(FREE_SLOTS);
    localparam int USED_IDX_W = $clog2(USED_SLOTS);

    localparam int OWNER_W  = 16;
    localparam int SIZE_W   = 32;
    localparam int LEN_W    = 32;
    localparam int REG_W    = 32;
    localparam int START_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam int IN_BITS  = OWNER_W + SIZE_W;
    localparam int OUT_BITS = STATUS_W + START_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] POOL_LENGTH_RESET = LEN_W'(1048576);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LENGTH = CFG_IDX_W'(1);

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RECORD_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_REQUEST = 2'd3;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

endpackage

// ===== hw/rtl/worst_fit_allocator.sv =====
// Top level: worst-fit allocator with a free-block table scanned by one shared comparator.
`timescale 1ns / 1ps

// Worst-fit allocator. Each item on the s_ side is an allocation request
// (owner id, byte size); each item on the m_ side is its answer (status and
// granted start address, zero unless ok). The free-block table is walked one
// slot per cycle through a single comparator that keeps the largest block
// big enough for the request, lowest start address on a tie; a commit cycle
// then cuts the request off the front of that block, releases the slot when
// it empties and records the grant in the lowest empty allocated-block slot.
// After the accepting edge the sequencer scans all FREE_SLOTS slots, then
// commits, loading the result into the output register that drives m_tvalid,
// and then returns to idle, where the next request can be taken. A new request
// is taken only once the previous one has committed, but a finished result
// may still be waiting in the output register meanwhile; commit waits for
// that register to empty, so a stall on m_tready holds the sequencer in
// commit. Writing pool_base or pool_length reloads both tables at once (free
// slot 0 holds the whole pool, everything else empty); writes are for idle
// periods only.
module worst_fit_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfa_pkg::REG_W-1:0]          cfg_wr_data,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wfa_pkg::IN_TDATA_W-1:0]     s_tdata,  // owner_id[15:0], request_size[47:16]
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [wfa_pkg::OUT_TDATA_W-1:0]    m_tdata   // status[1:0], block_start[33:2], zero pad
);

    // pool registers
    logic [wfa_pkg::REG_W-1:0] pool_base_reg;
    logic [wfa_pkg::LEN_W-1:0] pool_length_reg;
    logic                      cfg_hit;

    // free-block table
    logic [wfa_pkg::ADDR_WIDTH-1:0] free_base_reg   [wfa_pkg::FREE_SLOTS];
    logic [wfa_pkg::LEN_W-1:0]      free_length_reg [wfa_pkg::FREE_SLOTS];
    logic [wfa_pkg::FREE_SLOTS-1:0] free_valid_reg;

    // allocated-block table (entries only meaningful where valid)
    logic [wfa_pkg::OWNER_W-1:0]    used_owner_mem  [wfa_pkg::USED_SLOTS];
    logic [wfa_pkg::ADDR_WIDTH-1:0] used_base_mem   [wfa_pkg::USED_SLOTS];
    logic [wfa_pkg::SIZE_W-1:0]     used_length_mem [wfa_pkg::USED_SLOTS];
    logic [wfa_pkg::USED_SLOTS-1:0] used_valid_reg;

    // sequencer
    logic [1:0]                     state_reg, state_next;
    logic [wfa_pkg::FREE_IDX_W-1:0] idx_reg;
    logic                           idx_last;

    // request held for the length of the item
    logic [wfa_pkg::OWNER_W-1:0] owner_reg;
    logic [wfa_pkg::SIZE_W-1:0]  size_reg;
    logic                        bad_reg;

    // best candidate so far
    logic                           best_found_reg;
    logic [wfa_pkg::FREE_IDX_W-1:0] best_idx_reg;
    logic [wfa_pkg::ADDR_WIDTH-1:0] best_base_reg;
    logic [wfa_pkg::LEN_W-1:0]      best_len_reg;

    // shared comparator
    logic [wfa_pkg::ADDR_WIDTH-1:0] cand_base;
    logic [wfa_pkg::LEN_W-1:0]      cand_len;
    logic                           cand_fits;
    logic                           cand_better;

    // commit
    logic                           used_free;
    logic [wfa_pkg::USED_IDX_W-1:0] used_slot;
    logic [wfa_pkg::STATUS_W-1:0]   status_next;
    logic                           out_free;
    logic                           commit_go;
    logic                           grant;
    logic [wfa_pkg::LEN_W-1:0]      rem_len;
    logic [wfa_pkg::ADDR_WIDTH-1:0] new_base;

    // output register
    logic                           m_valid_reg;
    logic [wfa_pkg::STATUS_W-1:0]   m_status_reg;
    logic [wfa_pkg::START_W-1:0]    m_start_reg;

    logic in_accept;

    assign s_tready  = (state_reg == wfa_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_hit   = cfg_wr_en &&
                       (cfg_index == wfa_pkg::CFG_POOL_BASE ||
                        cfg_index == wfa_pkg::CFG_POOL_LENGTH);
    assign idx_last  = (idx_reg == wfa_pkg::FREE_IDX_W'(wfa_pkg::FREE_SLOTS - 1));

    // --- one comparator step per scan cycle ---
    assign cand_base = free_base_reg[idx_reg];
    assign cand_len  = free_length_reg[idx_reg];
    assign cand_fits = free_valid_reg[idx_reg] && (cand_len >= size_reg);
    assign cand_better = cand_fits &&
                         (!best_found_reg || (cand_len > best_len_reg) ||
                          ((cand_len == best_len_reg) && (cand_base < best_base_reg)));

    // lowest empty allocated-block slot
    always_comb begin
        used_free = 1'b0;
        used_slot = '0;
        for (int i = wfa_pkg::USED_SLOTS - 1; i >= 0; i--) begin
            if (!used_valid_reg[i]) begin
                used_free = 1'b1;
                used_slot = wfa_pkg::USED_IDX_W'(i);
            end
        end
    end

    // bad_request beats no_fit, which beats record_full
    always_comb begin
        if (bad_reg) begin
            status_next = wfa_pkg::STATUS_BAD_REQUEST;
        end else if (!best_found_reg) begin
            status_next = wfa_pkg::STATUS_NO_FIT;
        end else if (!used_free) begin
            status_next = wfa_pkg::STATUS_RECORD_FULL;
        end else begin
            status_next = wfa_pkg::STATUS_OK;
        end
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign commit_go = (state_reg == wfa_pkg::ST_COMMIT) && out_free;
    assign grant     = commit_go && (status_next == wfa_pkg::STATUS_OK);
    assign rem_len   = best_len_reg - wfa_pkg::LEN_W'(size_reg);
    assign new_base  = best_base_reg + wfa_pkg::ADDR_WIDTH'(size_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wfa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = wfa_pkg::ST_SCAN;
                end
            end
            wfa_pkg::ST_SCAN: begin
                if (idx_last) begin
                    state_next = wfa_pkg::ST_COMMIT;
                end
            end
            wfa_pkg::ST_COMMIT: begin
                if (out_free) begin
                    state_next = wfa_pkg::ST_IDLE;
                end
            end
            default: state_next = wfa_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wfa_pkg::ST_IDLE;
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
            end else if (state_reg == wfa_pkg::ST_SCAN) begin
                idx_reg <= idx_reg + 1'b1;
                if (cand_better) begin
                    best_found_reg <= 1'b1;
                end
            end
            if (commit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and best-candidate payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            owner_reg <= s_tdata[wfa_pkg::OWNER_W-1:0];
            size_reg  <= s_tdata[wfa_pkg::IN_BITS-1:wfa_pkg::OWNER_W];
            bad_reg   <= (s_tdata[wfa_pkg::OWNER_W-1:0] == '0) ||
                         (s_tdata[wfa_pkg::IN_BITS-1:wfa_pkg::OWNER_W] == '0);
        end
        if ((state_reg == wfa_pkg::ST_SCAN) && cand_better) begin
            best_idx_reg  <= idx_reg;
            best_base_reg <= cand_base;
            best_len_reg  <= cand_len;
        end
        if (commit_go) begin
            m_status_reg <= status_next;
            m_start_reg  <= grant ? wfa_pkg::START_W'(best_base_reg) : '0;
        end
    end

    // pool registers and valid bits; a config write reloads both tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= '0;
            pool_length_reg <= wfa_pkg::POOL_LENGTH_RESET;
            free_valid_reg  <= wfa_pkg::FREE_SLOTS'(1);
            used_valid_reg  <= '0;
        end else if (cfg_hit) begin
            if (cfg_index == wfa_pkg::CFG_POOL_BASE) begin
                pool_base_reg <= cfg_wr_data;
            end else begin
                pool_length_reg <= cfg_wr_data;
            end
            free_valid_reg <= wfa_pkg::FREE_SLOTS'(1);
            used_valid_reg <= '0;
        end else if (grant) begin
            used_valid_reg[used_slot] <= 1'b1;
            if (rem_len == '0) begin
                free_valid_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // free-table payload: slot 0 loaded from the pool on reset and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_base_reg[0]   <= '0;
            free_length_reg[0] <= wfa_pkg::POOL_LENGTH_RESET;
        end else if (cfg_hit) begin
            if (cfg_index == wfa_pkg::CFG_POOL_BASE) begin
                free_base_reg[0]   <= wfa_pkg::ADDR_WIDTH'(cfg_wr_data);
                free_length_reg[0] <= pool_length_reg;
            end else begin
                free_base_reg[0]   <= wfa_pkg::ADDR_WIDTH'(pool_base_reg);
                free_length_reg[0] <= cfg_wr_data;
            end
        end else if (grant) begin
            free_length_reg[best_idx_reg] <= rem_len;
            free_base_reg[best_idx_reg]   <= (rem_len == '0) ? '0 : new_base;
        end
    end

    // allocated-block records
    always_ff @(posedge aclk) begin
        if (grant) begin
            used_owner_mem[used_slot]  <= owner_reg;
            used_base_mem[used_slot]   <= best_base_reg;
            used_length_mem[used_slot] <= size_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = wfa_pkg::OUT_TDATA_W'({m_start_reg, m_status_reg});

endmodule

// ===== hw/rtl/wfa_checker.sv =====
// Checker: port-level properties of the worst-fit allocator, bound to the top level.
`timescale 1ns / 1ps

module wfa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wfa_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // start address only on a grant
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != wfa_pkg::STATUS_OK) |->
            m_tdata[wfa_pkg::OUT_BITS-1:wfa_pkg::STATUS_W] == '0)
        else $error("start address on a refused request");

    // no result can appear in the cycle after a fresh accept unless one was pending
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result before the scan finished");

endmodule

bind worst_fit_allocator wfa_checker u_wfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
